/* src/frtm_pkg.sv */
// Shared types and constants for the flow rate trimmed mean monitor.
// No dependencies.
package frtm_pkg;

  localparam int unsigned RateW = 24;
  localparam int unsigned SumW  = 32;
  localparam logic [RateW-1:0] Max24 = {RateW{1'b1}};
  localparam logic [31:0] RateNum = 32'd256000000;
  localparam logic [3:0] ValidCap = 4'd10;

  typedef enum logic [2:0] {
    REG_COEFF     = 3'd0,
    REG_MIN_RATE  = 3'd1,
    REG_MAX_RATE  = 3'd2,
    REG_THRESHOLD = 3'd3,
    REG_HOLD_TIME = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    STAT_GOOD = 2'd0,
    STAT_LOW  = 2'd1,
    STAT_HIGH = 2'd2
  } range_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE_DIV,
    ST_ACCUM,
    ST_PULSE_DIV,
    ST_FLOW_START,
    ST_FLOW_DIV,
    ST_SHIFT,
    ST_SCAN,
    ST_MEAN_LO,
    ST_MEAN_HI,
    ST_FINISH,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    DIV_RATE,
    DIV_PULSE,
    DIV_FLOW
  } div_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     div_start;
    div_sel_e div_sel;
    logic     accum;
    logic     shift_win;
    logic     scan_clear;
    logic     scan_step;
    logic     mean_lo;
    logic     mean_hi;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_update;
    logic div_done;
    logic scan_done;
  } dp_status_t;

endpackage

/* src/frtm_divider.sv */
// Restoring divider, one quotient bit per cycle, 40-bit dividend, 32-bit divisor.
// Depends on frtm_pkg only through the import convention.
module frtm_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [39:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [39:0] quotient_o
);
  import frtm_pkg::*;

  logic [39:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    shifted = {rem_q[31:0], quo_q[39]};
    trial   = shifted - {1'b0, dvs_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = 6'd40;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial;
        quo_d = {quo_q[38:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[38:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

/* src/frtm_datapath.sv */
// Datapath: input capture, accumulator, window, scan and update logic.
// Depends on frtm_pkg and frtm_divider.
module frtm_datapath #(
  parameter int unsigned WindowLen  = 10,
  parameter int unsigned MaxSamples = 255
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  frtm_pkg::dp_cmd_t        cmd_i,
  output frtm_pkg::dp_status_t     status_o,
  input  logic                     func_i,
  input  logic [23:0]              period_us_i,
  input  logic [31:0]              now_ms_i,
  input  logic [15:0]              coefficient_q8_i,
  input  logic [23:0]              min_rate_i,
  input  logic [23:0]              max_rate_i,
  input  logic [23:0]              enable_threshold_i,
  input  logic [15:0]              hold_time_ms_i,
  output logic [23:0]              flow_rate_o,
  output logic [23:0]              pulse_rate_o,
  output logic [1:0]               range_status_o,
  output logic [3:0]               valid_count_o,
  output logic                     spraying_on_o
);
  import frtm_pkg::*;

  localparam int unsigned IdxW = $clog2(WindowLen);
  localparam int unsigned WsumW = RateW + $clog2(WindowLen + 1);
  // trimmed mean: floor(x / TrimD) as x * Recip >> MulK, in two 16-bit halves
  localparam int unsigned TrimD = WindowLen - 2;
  localparam int unsigned MulK  = WsumW + $clog2(TrimD);
  localparam int unsigned PartW = WsumW + 16;
  localparam int unsigned ProdW = WsumW + 32;
  localparam logic [63:0] Recip = ((64'd1 << MulK) + 64'(TrimD) - 64'd1) / 64'(TrimD);
  localparam logic [15:0] RecipLo = Recip[15:0];
  localparam logic [15:0] RecipHi = Recip[31:16];

  logic        func_q;
  logic [23:0] period_q;
  logic [31:0] now_q;
  logic [31:0] rate_sum_q;
  logic [7:0]  sample_count_q;
  logic [23:0] win_q [WindowLen];
  logic [23:0] pulse_q, flow_q, mean_q, hi_q, lo_q;
  logic [WsumW-1:0] wsum_q;
  logic [IdxW-1:0] idx_q;
  logic [3:0]  good_q;
  logic [31:0] hold_start_q;
  logic        hold_started_q, enabled_q;
  logic [1:0]  status_q;
  logic [ProdW-1:0] prod_q;

  logic        div_done;
  logic [39:0] div_q;
  logic [39:0] dvd;
  logic [31:0] dvs;
  logic [23:0] div_sat;
  logic [23:0] rate_n;
  logic [23:0] cur;
  logic [32:0] acc;
  logic [23:0] mean_n;
  logic [1:0]  stat_n;
  logic [WsumW-1:0] trimmed;
  logic [15:0] recip_half;
  logic [PartW-1:0] part;
  logic [ProdW-1:0] prod_sum;
  logic [ProdW-1:0] mean_wide;

  assign div_sat = (div_q[39:24] != '0) ? Max24 : div_q[23:0];
  assign trimmed = wsum_q - WsumW'(hi_q) - WsumW'(lo_q);

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_RATE:  begin dvd = 40'(RateNum);             dvs = 32'(period_q); end
      DIV_PULSE: begin dvd = 40'(rate_sum_q);          dvs = 32'(sample_count_q); end
      DIV_FLOW:  begin dvd = {8'd0, pulse_q, 8'd0};    dvs = 32'(coefficient_q8_i); end
      default:   begin dvd = '0;                       dvs = '0; end
    endcase
  end

  frtm_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign rate_n = (period_q == '0) ? Max24 : div_sat;
  assign cur = win_q[idx_q];
  assign acc = {1'b0, rate_sum_q} + 33'(rate_n);

  assign recip_half = cmd_i.mean_hi ? RecipHi : RecipLo;
  assign part       = PartW'(trimmed) * PartW'(recip_half);
  assign prod_sum   = prod_q + (ProdW'(part) << 16);
  assign mean_wide  = prod_sum >> MulK;
  assign mean_n     = mean_wide[23:0];

  always_comb begin
    priority if (mean_q > max_rate_i) stat_n = STAT_HIGH;
    else if (mean_q < min_rate_i)     stat_n = STAT_LOW;
    else                              stat_n = STAT_GOOD;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q   <= func_i;
      period_q <= period_us_i;
      now_q    <= now_ms_i;
    end
    if (div_done) begin
      unique case (cmd_i.div_sel)
        DIV_RATE:  ;
        DIV_PULSE: pulse_q <= (sample_count_q == '0) ? '0 : div_sat;
        DIV_FLOW:  flow_q  <= (coefficient_q8_i == '0) ? Max24 : div_sat;
        default:   ;
      endcase
    end
    if (cmd_i.mean_lo) prod_q <= ProdW'(part);
    if (cmd_i.mean_hi) mean_q <= mean_n;
    if (cmd_i.scan_clear) begin
      wsum_q <= '0;
      hi_q   <= '0;
      lo_q   <= Max24;
    end else if (cmd_i.scan_step) begin
      wsum_q <= wsum_q + WsumW'(cur);
      if (cur > hi_q) hi_q <= cur;
      if (cur < lo_q) lo_q <= cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_sum_q     <= '0;
      sample_count_q <= '0;
      for (int i = 0; i < WindowLen; i++) win_q[i] <= '0;
      idx_q          <= '0;
      good_q         <= '0;
      hold_start_q   <= '0;
      hold_started_q <= 1'b0;
      enabled_q      <= 1'b0;
      status_q       <= STAT_GOOD;
    end else begin
      if (cmd_i.accum && sample_count_q < 8'(MaxSamples)) begin
        rate_sum_q     <= acc[32] ? 32'hFFFF_FFFF : acc[31:0];
        sample_count_q <= sample_count_q + 8'd1;
      end
      if (cmd_i.shift_win) begin
        for (int i = 1; i < WindowLen; i++) win_q[i-1] <= win_q[i];
        win_q[WindowLen-1] <= flow_q;
        rate_sum_q     <= '0;
        sample_count_q <= '0;
      end
      if (cmd_i.scan_clear) idx_q <= '0;
      else if (cmd_i.scan_step) idx_q <= idx_q + IdxW'(1);
      if (cmd_i.finish) begin
        status_q <= stat_n;
        if (stat_n == STAT_GOOD) begin
          if (good_q < ValidCap) good_q <= good_q + 4'd1;
        end else begin
          good_q <= '0;
        end
        if (mean_q > enable_threshold_i && !enabled_q) begin
          if (!hold_started_q) begin
            hold_started_q <= 1'b1;
            hold_start_q   <= now_q;
          end else if ((now_q - hold_start_q) > 32'(hold_time_ms_i)) begin
            enabled_q <= 1'b1;
          end
        end else begin
          hold_started_q <= 1'b0;
          hold_start_q   <= '0;
        end
      end
    end
  end

  assign status_o.is_update = func_q;
  assign status_o.div_done  = div_done;
  assign status_o.scan_done = (idx_q == IdxW'(WindowLen - 1));

  assign flow_rate_o    = mean_q;
  assign pulse_rate_o   = pulse_q;
  assign range_status_o = status_q;
  assign valid_count_o  = good_q;
  assign spraying_on_o  = enabled_q;
endmodule

/* src/frtm_ctrl.sv */
// Controller state machine sequencing the datapath per item.
// Depends on frtm_pkg.
module frtm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  frtm_pkg::dp_status_t status_i,
  output frtm_pkg::dp_cmd_t    cmd_o
);
  import frtm_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:       if (in_valid) state_d = ST_RATE_DIV;
      ST_RATE_DIV:   state_d = status_i.is_update ? ST_PULSE_DIV : ST_ACCUM;
      ST_ACCUM:      if (status_i.div_done) state_d = ST_IDLE;
      ST_PULSE_DIV:  if (status_i.div_done) state_d = ST_FLOW_START;
      ST_FLOW_START: state_d = ST_FLOW_DIV;
      ST_FLOW_DIV:   if (status_i.div_done) state_d = ST_SHIFT;
      ST_SHIFT:      state_d = ST_SCAN;
      ST_SCAN:       if (status_i.scan_done) state_d = ST_MEAN_LO;
      ST_MEAN_LO:    state_d = ST_MEAN_HI;
      ST_MEAN_HI:    state_d = ST_FINISH;
      ST_FINISH:     state_d = ST_OUT;
      ST_OUT:        if (out_ready) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.div_sel = DIV_RATE;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd_o.load_in = in_valid;
      end
      ST_RATE_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = status_i.is_update ? DIV_PULSE : DIV_RATE;
      end
      ST_ACCUM: begin
        cmd_o.div_sel = DIV_RATE;
        cmd_o.accum   = status_i.div_done;
      end
      ST_PULSE_DIV: begin
        cmd_o.div_sel = DIV_PULSE;
      end
      ST_FLOW_START: begin
        cmd_o.div_sel   = DIV_FLOW;
        cmd_o.div_start = 1'b1;
      end
      ST_FLOW_DIV: begin
        cmd_o.div_sel = DIV_FLOW;
      end
      ST_SHIFT: begin
        cmd_o.shift_win  = 1'b1;
        cmd_o.scan_clear = 1'b1;
      end
      ST_SCAN:    cmd_o.scan_step = 1'b1;
      ST_MEAN_LO: cmd_o.mean_lo   = 1'b1;
      ST_MEAN_HI: cmd_o.mean_hi   = 1'b1;
      ST_FINISH:  cmd_o.finish    = 1'b1;
      ST_OUT:     out_valid       = 1'b1;
      default: ;
    endcase
  end
endmodule

/* src/flow_rate_trimmed_mean_monitor.sv */
// Top level of the flow rate trimmed mean monitor.
// Depends on frtm_pkg, frtm_ctrl, frtm_datapath.
//
// Input channel (in_valid/in_ready): func_i 0 carries a pulse period sample,
// func_i 1 an update tick with the time in ms. Samples produce no output; each
// update produces one transfer on the output channel (out_valid/out_ready).
// Config channel (cfg_valid/cfg_ready, cfg_index_i, cfg_data_i) is always
// ready; write only while the block is idle.
// A sample is handled with one bit-serial divide and an accumulate step.
// An update runs the pulse and flow divides, the window scan and a reciprocal
// multiply in two 16-bit halves for the trimmed mean before its result shows.
// One item is processed at a time; the next is taken once the controller has
// returned from the output state to idle.
// The result is held on the outputs until out_ready; no new item is taken
// while it waits.
// Reset clears the accumulator, the window, counters, the flag and restores
// register defaults.
module flow_rate_trimmed_mean_monitor #(
  parameter int unsigned WINDOW_LEN  = 10,
  parameter int unsigned MAX_SAMPLES = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func_i,
  input  logic [23:0] period_us_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] flow_rate_o,
  output logic [23:0] pulse_rate_o,
  output logic [1:0]  range_status_o,
  output logic [3:0]  valid_count_o,
  output logic        spraying_on_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  import frtm_pkg::*;

  logic [15:0] coeff_q;
  logic [23:0] min_q, max_q, thr_q;
  logic [15:0] hold_q;
  dp_cmd_t     cmd;
  dp_status_t  st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= 16'd4096;
      min_q   <= 24'd0;
      max_q   <= 24'd2560;
      thr_q   <= 24'd256;
      hold_q  <= 16'd1000;
    end else if (cfg_valid) begin
      unique case (cfg_index_i)
        REG_COEFF:     coeff_q <= cfg_data_i[15:0];
        REG_MIN_RATE:  min_q   <= cfg_data_i;
        REG_MAX_RATE:  max_q   <= cfg_data_i;
        REG_THRESHOLD: thr_q   <= cfg_data_i;
        REG_HOLD_TIME: hold_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  frtm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status_i  (st),
    .cmd_o     (cmd)
  );

  frtm_datapath #(
    .WindowLen  (WINDOW_LEN),
    .MaxSamples (MAX_SAMPLES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (st),
    .func_i             (func_i),
    .period_us_i        (period_us_i),
    .now_ms_i           (now_ms_i),
    .coefficient_q8_i   (coeff_q),
    .min_rate_i         (min_q),
    .max_rate_i         (max_q),
    .enable_threshold_i (thr_q),
    .hold_time_ms_i     (hold_q),
    .flow_rate_o        (flow_rate_o),
    .pulse_rate_o       (pulse_rate_o),
    .range_status_o     (range_status_o),
    .valid_count_o      (valid_count_o),
    .spraying_on_o      (spraying_on_o)
  );
endmodule
